// ===== rtl/edge_following_steering_pid_defines.svh =====
// assertion macros shared by the checker
`ifndef EDGE_FOLLOWING_STEERING_PID_DEFINES_SVH
`define EDGE_FOLLOWING_STEERING_PID_DEFINES_SVH
// property that must hold at every clock edge outside reset
`define EFS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// property that must hold also while reset is applied
`define EFS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ===== rtl/efsp_pkg.sv =====
package efsp_pkg;
  localparam int FracBits = 16;
  localparam int CordicSteps = 16;
  localparam logic [30:0] LinearGainCollide = 31'd32768;
  localparam logic [30:0] LinearGainRear = 31'd32768;
  localparam int CfgCount = 8;

  localparam logic [2:0] RegTargetDistance = 3'd0;
  localparam logic [2:0] RegSpareDistance = 3'd1;
  localparam logic [2:0] RegLinearGainTrack = 3'd2;
  localparam logic [2:0] RegAngularGainTrack = 3'd3;
  localparam logic [2:0] RegAngularIntegralGain = 3'd4;
  localparam logic [2:0] RegAngularDerivativeGain = 3'd5;
  localparam logic [2:0] RegAngularGainCollide = 3'd6;
  localparam logic [2:0] RegAngularGainRear = 3'd7;

  localparam logic [1:0] ModeCollide = 2'd0;
  localparam logic [1:0] ModeRear = 2'd1;
  localparam logic [1:0] ModeTrack = 2'd2;

  typedef struct packed {
    logic signed [31:0] edge_distance;
    logic signed [31:0] angle_difference;
    logic edge_on_left;
    logic signed [31:0] direction_x;
    logic signed [31:0] direction_y;
  } in_word_t;

  typedef struct packed {
    logic [15:0] linear_velocity;
    logic signed [31:0] angular_velocity;
    logic [1:0] mode;
    logic saturated;
  } out_word_t;

  // arctangent in degrees rounded from Q.24 to the fraction width
  function automatic logic signed [31:0] atan_deg(input logic [4:0] i);
    logic [31:0] a;
    case (i)
      5'd0: a = 754974720; 5'd1: a = 445687602; 5'd2: a = 235489089;
      5'd3: a = 119537938; 5'd4: a = 60000934; 5'd5: a = 30029717;
      5'd6: a = 15018523; 5'd7: a = 7509720; 5'd8: a = 3754917;
      5'd9: a = 1877466; 5'd10: a = 938734; 5'd11: a = 469367;
      5'd12: a = 234684; 5'd13: a = 117342; 5'd14: a = 58671;
      5'd15: a = 29335; 5'd16: a = 14668; 5'd17: a = 7334;
      5'd18: a = 3667; 5'd19: a = 1833; 5'd20: a = 917; 5'd21: a = 458;
      5'd22: a = 229; 5'd23: a = 115; 5'd24: a = 57; 5'd25: a = 29;
      5'd26: a = 14; 5'd27: a = 7; 5'd28: a = 4; 5'd29: a = 2;
      5'd30: a = 1;
      default: a = 0;
    endcase
    if (24 > FracBits) a = (a + (32'd1 << (23 - FracBits))) >> (24 - FracBits);
    return $signed(a);
  endfunction
endpackage

// ===== rtl/efsp_mul.sv =====
// registered signed 33x33 multiplier with floor shift by the fraction width
module efsp_mul import efsp_pkg::*; (
  input  logic               clk,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic signed [65:0] p,
  output logic signed [65:0] p_shr
);
  always_ff @(posedge clk) begin
    p <= a * b;
  end
  assign p_shr = p >>> FracBits;
endmodule

// ===== rtl/edge_following_steering_pid.sv =====
// Edge-following steering controller. One edge word is taken when in_ready is
// high; the block then drops in_ready and works the word through a small
// sequencer around one shared 33x33 multiplier, one restoring square-root unit
// (one result bit per cycle), one restoring divider (one quotient bit per cycle)
// and one CORDIC stage. A word passes through two 32-step square roots, a
// 64-step division (skipped when the direction x is zero), the CORDIC
// rotations and the multiply and bookkeeping states. The result word sits in
// an output register, and the next input word is taken once that register
// has been emptied, so no new word is taken before the last result has left.
// Registers are written through cfg_we; keeping writes to idle time is up to
// the user, as the block itself does not enforce it. The PID state (integral
// and previous heading) clears on reset.
module edge_following_steering_pid import efsp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [30:0] cfg_data
);
  typedef enum logic [4:0] {
    S_IDLE, S_SQ1, S_SQ2, S_SQRT1, S_CMUL, S_CMUL2, S_DIVINIT, S_DIV,
    S_SLOPE, S_SQ3, S_SQ3W, S_SQRT2, S_CORDIC, S_PID1, S_PID2, S_PID3,
    S_PID4, S_LIN, S_LINW, S_DONE
  } state_t;

  state_t state;
  logic [30:0] cfg [CfgCount];

  // captured word
  logic left;
  logic signed [32:0] vx, vy;
  logic [1:0] mode;
  logic sat;
  logic signed [31:0] hint, perr;

  // working registers
  logic [63:0] acc;         // first square / sqrt remainder
  logic [63:0] rem;
  logic [31:0] root;
  logic [5:0] cnt;
  logic signed [48:0] num;
  logic [63:0] dquo;
  logic [33:0] drem;
  logic [63:0] dnum;
  logic signed [31:0] slope;
  logic [31:0] tn;
  logic signed [63:0] cx, cy;
  logic signed [31:0] cz;
  logic signed [63:0] wsum;
  logic signed [32:0] diff;

  // shared multiplier
  logic signed [32:0] ma, mb;
  logic signed [65:0] mp, mps;
  efsp_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(mp), .p_shr(mps));

  // mode choice
  logic signed [31:0] lim20;
  logic cmode, rmode;
  assign lim20 = 32'sd20 <<< FracBits;
  assign cmode = in_data.edge_on_left ? (in_data.angle_difference < -lim20)
                                      : (in_data.angle_difference > lim20);
  assign rmode = in_data.edge_on_left ? (in_data.angle_difference > lim20)
                                      : (in_data.angle_difference < -lim20);

  // distance error, clamped
  logic signed [33:0] derr;
  logic signed [32:0] derr_c;
  assign derr = 34'(in_data.edge_distance) - 34'($signed({1'b0, cfg[RegTargetDistance]}))
              - (rmode ? 34'($signed({1'b0, cfg[RegSpareDistance]})) : 34'sd0);
  assign derr_c = derr > 34'sh7FFFFFFF ? 33'sh7FFFFFFF :
                  (derr < -34'sh80000000 ? -33'sh80000000 : 33'(derr));
  logic signed [32:0] err;

  // cordic step
  logic signed [63:0] cdx, cdy;
  logic signed [31:0] ca;
  assign cdx = cy >>> cnt[4:0];
  assign cdy = cx >>> cnt[4:0];
  assign ca = atan_deg(cnt[4:0]);

  logic signed [33:0] hsum;
  logic signed [31:0] hint_c;
  assign hsum = 34'(hint) + 34'(cz);
  assign hint_c = hsum > 34'sh7FFFFFFF ? 32'sh7FFFFFFF :
                  (hsum < -34'sh80000000 ? -32'sh80000000 : 32'(hsum));

  logic [34:0] dtrial;
  assign dtrial = {drem, dnum[63]} - {1'b0, vx};

  logic [63:0] lin;
  assign lin = 64'(mp);

  assign in_ready = (state == S_IDLE) && !out_valid;

  always_comb begin
    ma = 33'sd0;
    mb = 33'sd0;
    case (state)
      S_IDLE: begin ma = 33'(in_data.direction_x); mb = 33'(in_data.direction_x); end
      S_SQ1:  begin ma = vy; mb = vy; end
      S_CMUL: begin ma = $signed({1'b0, root}); mb = err; end
      S_SQ3:  begin ma = 33'(slope); mb = 33'(slope); end
      S_PID1: begin
        ma = 33'(cz);
        mb = $signed({2'b0, mode == ModeTrack ? cfg[RegAngularGainTrack] :
               (mode == ModeCollide ? cfg[RegAngularGainCollide]
                                    : cfg[RegAngularGainRear])});
      end
      S_PID2: begin ma = 33'(hint); mb = $signed({2'b0, cfg[RegAngularIntegralGain]}); end
      S_PID3: begin ma = diff; mb = $signed({2'b0, cfg[RegAngularDerivativeGain]}); end
      S_LIN:  begin
        ma = $signed({1'b0, tn});
        mb = $signed({2'b0, mode == ModeTrack ? cfg[RegLinearGainTrack] :
               (mode == ModeCollide ? LinearGainCollide : LinearGainRear)});
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      hint <= '0;
      perr <= '0;
      cfg[RegTargetDistance] <= 31'd45875;
      cfg[RegSpareDistance] <= 31'd32768;
      cfg[RegLinearGainTrack] <= 31'd32768;
      cfg[RegAngularGainTrack] <= 31'd6554;
      cfg[RegAngularIntegralGain] <= 31'd6554;
      cfg[RegAngularDerivativeGain] <= 31'd6554;
      cfg[RegAngularGainCollide] <= 31'd6554;
      cfg[RegAngularGainRear] <= 31'd6554;
    end else begin
      if (cfg_we) cfg[cfg_index] <= cfg_data;
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (in_valid && in_ready) begin
          // flip so that x is not negative
          vx <= in_data.direction_x < 0 ? -33'(in_data.direction_x) : 33'(in_data.direction_x);
          vy <= in_data.direction_x < 0 ? -33'(in_data.direction_y) : 33'(in_data.direction_y);
          left <= in_data.edge_on_left;
          mode <= cmode ? ModeCollide : (rmode ? ModeRear : ModeTrack);
          err <= derr_c;
          sat <= 1'b0;
          state <= S_SQ1;
        end
        S_SQ1: begin acc <= 64'(mp); state <= S_SQ2; end
        S_SQ2: begin
          rem <= acc + 64'(mp);
          acc <= '0; root <= '0; cnt <= '0;
          state <= S_SQRT1;
        end
        S_SQRT1, S_SQRT2: begin
          // restoring square root, one result bit per cycle
          if ({acc[61:0], rem[63:62]} >= {root, 2'b01}) begin
            acc <= {acc[61:0], rem[63:62]} - {root, 2'b01};
            root <= {root[30:0], 1'b1};
          end else begin
            acc <= {acc[61:0], rem[63:62]};
            root <= {root[30:0], 1'b0};
          end
          rem <= {rem[61:0], 2'b00};
          // count restarts for the cordic loop
          cnt <= (cnt == 6'd31) ? 6'd0 : cnt + 6'd1;
          if (cnt == 6'd31) state <= (state == S_SQRT1) ? S_CMUL : S_CORDIC;
          if (cnt == 6'd31 && state == S_SQRT2) begin
            cx <= 64'sd1 <<< FracBits; cy <= 64'(slope); cz <= '0;
          end
        end
        S_CMUL: state <= S_CMUL2;
        S_CMUL2: begin
          // offset can reach 47 bits, so the numerator is kept wide
          num <= 49'(vy) + (left ? 49'(mps) : -49'(mps));
          state <= S_DIVINIT;
        end
        S_DIVINIT: begin
          dnum <= 64'(num < 0 ? -num : num) << FracBits;
          drem <= '0; dquo <= '0; cnt <= '0;
          state <= (vx == 0) ? S_SLOPE : S_DIV;
        end
        S_DIV: begin
          if (!dtrial[34]) begin
            drem <= dtrial[33:0]; dquo <= {dquo[62:0], 1'b1};
          end else begin
            drem <= {drem[32:0], dnum[63]}; dquo <= {dquo[62:0], 1'b0};
          end
          dnum <= {dnum[62:0], 1'b0};
          cnt <= cnt + 6'd1;
          if (cnt == 6'd63) state <= S_SLOPE;
        end
        S_SLOPE: begin
          if (vx == 0) begin
            sat <= 1'b1;
            slope <= num > 0 ? 32'sh7FFFFFFF : (num < 0 ? -32'sh80000000 : 32'sd0);
          end else if (dquo[63:31] != 0) begin
            sat <= 1'b1;
            slope <= num < 0 ? -32'sh80000000 : 32'sh7FFFFFFF;
          end else begin
            slope <= num < 0 ? -$signed(dquo[31:0]) : $signed(dquo[31:0]);
          end
          state <= S_SQ3;
        end
        S_SQ3: state <= S_SQ3W;
        S_SQ3W: begin
          rem <= (64'd1 << (2 * FracBits)) + 64'(mp);
          acc <= '0; root <= '0; cnt <= '0;
          state <= S_SQRT2;
        end
        S_CORDIC: begin
          if (cnt == 6'(CordicSteps) || cnt == 6'd32) begin
            tn <= root;
            state <= S_PID1;
          end else begin
            if (cy > 0) begin
              cx <= cx + cdx; cy <= cy - cdy; cz <= cz + ca;
            end else begin
              cx <= cx - cdx; cy <= cy + cdy; cz <= cz - ca;
            end
            cnt <= cnt + 6'd1;
          end
        end
        S_PID1: begin
          diff <= 33'(cz) - 33'(perr);
          if (mode == ModeTrack) begin
            if (hsum != 34'(hint_c)) sat <= 1'b1;
            hint <= hint_c;
            perr <= cz;
          end else begin
            hint <= '0; perr <= '0;
          end
          state <= S_PID2;
        end
        S_PID2: begin wsum <= 64'(mps); state <= S_PID3; end
        S_PID3: begin
          if (mode == ModeTrack) wsum <= wsum + 64'(mps);
          state <= S_PID4;
        end
        S_PID4: begin
          if (mode == ModeTrack) wsum <= wsum + 64'(mps);
          state <= S_LIN;
        end
        S_LIN: state <= S_LINW;
        S_LINW: begin
          out_data.linear_velocity <=
            ((lin >> FracBits) > (64'd1 << (FracBits - 1))) ?
            16'(64'd1 << (FracBits - 1)) : 16'(lin >> FracBits);
          out_data.angular_velocity <=
            wsum > (64'sd5 <<< FracBits) ? 32'(64'sd5 <<< FracBits) :
            (wsum < -64'sh80000000 ? -32'sh80000000 : 32'(wsum));
          out_data.mode <= mode;
          out_data.saturated <= sat;
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/efsp_checker.sv =====
`include "edge_following_steering_pid_defines.svh"
module efsp_checker import efsp_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_word_t out_data
);
  `EFS_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_data), "result word dropped or changed while stalled")
  `EFS_ASSERT(a_busy, clk, rst, in_valid && in_ready |=> !in_ready, "input taken while busy")
  `EFS_ASSERT(a_mode, clk, rst, out_valid |-> out_data.mode != 2'd3, "bad mode code")
  `EFS_ASSERT(a_lin, clk, rst, out_valid |-> out_data.linear_velocity <= 16'd32768, "speed above cap")
  `EFS_ASSERT_ALWAYS(a_rst, clk, rst |=> !out_valid, "result after reset")
endmodule

bind edge_following_steering_pid efsp_checker u_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
